[rtl/core/arp_resolver_cache_defines.svh]
// Assertion macros shared by the ARP resolver cache RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ARP_RESOLVER_CACHE_DEFINES_SVH
`define ARP_RESOLVER_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/arpc_pkg.sv]
// Shared types and constants of the ARP resolver cache.
// No dependencies; the front, queue, back and top files use it by scoped names.
`timescale 1ns / 1ps

package arpc_pkg;

    // Default sizes.
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int HANDLE_BITS_DEF = 8;
    localparam int MAX_RESULTS     = 16;
    localparam int QUEUE_DEPTH     = 2;

    // ARP header values that are accepted.
    localparam logic [15:0] HW_ETHER       = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

    // Input opcodes.
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ARP  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OWN_IP  = 1'b0;
    localparam logic CFG_OWN_MAC = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_REPLY   = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MATCH,
        BS_PICK,
        BS_EXEC,
        BS_REL,
        BS_EMIT
    } back_state_t;

    // Command handed from the front to the back.
    typedef struct packed {
        logic        is_arp;
        logic        is_req;
        logic [31:0] ip;
        logic [7:0]  handle;
        logic [31:0] s_ip;
        logic [47:0] s_mac;
    } cmd_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  handle;
        logic [31:0] ip;
        logic [47:0] mac;
        logic        last;
    } result_t;

endpackage

[rtl/core/arpc_if.sv]
// Channel interfaces of the ARP resolver cache: input, result and configuration.
// Depends on nothing.
`timescale 1ns / 1ps

interface arpc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] ip_addr;
    logic [7:0]  packet_handle;
    logic [15:0] hw_space;
    logic [15:0] proto_space;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_op;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;

    modport source (output valid, opcode, ip_addr, packet_handle, hw_space, proto_space,
                    hw_len, proto_len, arp_op, sender_ip, sender_mac, input ready);
    modport sink (input valid, opcode, ip_addr, packet_handle, hw_space, proto_space,
                  hw_len, proto_len, arp_op, sender_ip, sender_mac, output ready);
endinterface

interface arpc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_handle;
    logic [31:0] peer_ip;
    logic [47:0] peer_mac;
    logic        last;

    modport source (output valid, kind, out_handle, peer_ip, peer_mac, last, input ready);
    modport sink (input valid, kind, out_handle, peer_ip, peer_mac, last, output ready);
endinterface

interface arpc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/arpc_front.sv]
// Front end: accepts input requests, checks ARP headers and builds commands.
// Depends on arpc_pkg and arpc_in_if.
`timescale 1ns / 1ps

module arpc_front #(
    parameter int HANDLE_BITS = arpc_pkg::HANDLE_BITS_DEF
) (
    arpc_in_if.sink         rx,
    output logic            push_valid,
    input  logic            push_ready,
    output arpc_pkg::cmd_t  push_cmd
);

    localparam int HB = (HANDLE_BITS < 8) ? HANDLE_BITS : 8;
    localparam logic [7:0] HANDLE_MASK = 8'((1 << HB) - 1);

    logic hdr_ok;

    // A request is taken whenever the queue has room; bad ARP headers are discarded.
    assign hdr_ok = (rx.hw_space == arpc_pkg::HW_ETHER) &&
                    (rx.hw_len == arpc_pkg::HW_ADDR_LEN) &&
                    (rx.proto_space == arpc_pkg::PROTO_IPV4) &&
                    (rx.proto_len == arpc_pkg::PROTO_ADDR_LEN);

    assign rx.ready   = push_ready;
    assign push_valid = rx.valid && ((rx.opcode == arpc_pkg::OP_SEND) || hdr_ok);

    // Classify the request into a command.
    always_comb
    begin
        push_cmd.is_arp = (rx.opcode == arpc_pkg::OP_ARP);
        push_cmd.is_req = (rx.arp_op == arpc_pkg::ARP_OP_REQUEST);
        push_cmd.ip     = rx.ip_addr;
        push_cmd.handle = rx.packet_handle & HANDLE_MASK;
        push_cmd.s_ip   = rx.sender_ip;
        push_cmd.s_mac  = rx.sender_mac;
    end

endmodule

[rtl/core/arpc_cmd_queue.sv]
// Short command queue between the front and back ends.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  arpc_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output arpc_pkg::cmd_t  pop_cmd
);

    localparam int QD  = arpc_pkg::QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    arpc_pkg::cmd_t   slots_reg [QD];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != QCW'(QD));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/core/arpc_back.sv]
// Back end: address table, waiting store, configuration and result register.
// Depends on arpc_pkg, arpc_if and arp_resolver_cache_defines.svh.
`timescale 1ns / 1ps
`include "arp_resolver_cache_defines.svh"

module arpc_back #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF,
    parameter int WAIT_DEPTH  = arpc_pkg::WAIT_DEPTH_DEF,
    parameter int HANDLE_BITS = arpc_pkg::HANDLE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  arpc_pkg::cmd_t  pop_cmd,
    arpc_cfg_if.sink        cfg,
    arpc_out_if.source      tx
);

    localparam int TD  = TABLE_DEPTH;
    localparam int WD  = WAIT_DEPTH;
    localparam int HB  = (HANDLE_BITS < 8) ? HANDLE_BITS : 8;
    localparam int TIW = (TD > 1) ? $clog2(TD) : 1;
    localparam int WIW = (WD > 1) ? $clog2(WD) : 1;
    localparam int WCW = $clog2(WD + 1);
    localparam int CW  = $clog2(arpc_pkg::MAX_RESULTS + 1);

    arpc_pkg::back_state_t state_reg, state_next;
    arpc_pkg::cmd_t        cmd_reg, cmd_next;
    arpc_pkg::result_t     out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           own_ip_reg, own_ip_next;

    logic [TD-1:0]         entry_valid_reg, entry_valid_next;
    logic [31:0]           entry_ip_reg [TD];
    logic [47:0]           entry_mac_mem [TD];
    logic [TIW-1:0]        replace_ptr_reg, replace_ptr_next;
    logic [WD-1:0]         wait_valid_reg, wait_valid_next;
    logic [31:0]           wait_ip_reg [WD];
    logic [HB-1:0]         wait_handle_mem [WD];

    logic [TD-1:0]         tmatch, tmatch_reg, tmatch_next;
    logic [WD-1:0]         wmatch;
    logic                  tfree_any_reg, tfree_any_next;
    logic [TIW-1:0]        tfree_slot_reg, tfree_slot_next;
    logic                  wfree_any_reg, wfree_any_next;
    logic [WIW-1:0]        wfree_slot_reg, wfree_slot_next;
    logic [WCW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [WIW-1:0]        widx;
    logic [31:0]           key;
    logic                  out_can, more, hit;
    logic [TIW-1:0]        hit_slot;

    logic                  mac_we;
    logic [TIW-1:0]        mac_waddr;
    logic [47:0]           mac_rd_reg;
    logic                  ent_we;
    logic [TIW-1:0]        ent_waddr;
    logic                  wh_we;
    logic [HB-1:0]         wh_rd_reg;

    function automatic logic [TIW-1:0] low_t(input logic [TD-1:0] v);
        logic [TIW-1:0] r;
        r = '0;
        for (int i = TD - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = TIW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WIW-1:0] low_w(input logic [WD-1:0] v);
        logic [WIW-1:0] r;
        r = '0;
        for (int i = WD - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WIW'(i);
            end
        end
        return r;
    endfunction

    assign cfg.ready = 1'b1;
    assign widx      = idx_reg[WIW-1:0];
    assign key       = cmd_reg.is_arp ? cmd_reg.s_ip : cmd_reg.ip;
    assign out_can   = !out_valid_reg || tx.ready;
    assign hit       = |tmatch_reg;
    assign hit_slot  = low_t(tmatch_reg);

    assign tx.valid      = out_valid_reg;
    assign tx.kind       = out_reg.kind;
    assign tx.out_handle = out_reg.handle;
    assign tx.peer_ip    = out_reg.ip;
    assign tx.peer_mac   = out_reg.mac;
    assign tx.last       = out_reg.last;

    // Parallel compare against table and waiting store.
    always_comb
    begin
        for (int i = 0; i < TD; i++)
        begin
            tmatch[i] = entry_valid_reg[i] && (entry_ip_reg[i] == key);
        end
        for (int j = 0; j < WD; j++)
        begin
            wmatch[j] = wait_valid_reg[j] && (wait_ip_reg[j] == cmd_reg.s_ip);
        end
    end

    // Any match in the waiting store past the current scan position.
    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < WD; j++)
        begin
            if (wmatch[j] && (WCW'(j) > idx_reg))
            begin
                more = 1'b1;
            end
        end
    end

    // Sequencer for one command.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg && !tx.ready;
        own_ip_next      = own_ip_reg;
        entry_valid_next = entry_valid_reg;
        replace_ptr_next = replace_ptr_reg;
        wait_valid_next  = wait_valid_reg;
        tmatch_next      = tmatch_reg;
        tfree_any_next   = tfree_any_reg;
        tfree_slot_next  = tfree_slot_reg;
        wfree_any_next   = wfree_any_reg;
        wfree_slot_next  = wfree_slot_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        pop_ready        = 1'b0;
        mac_we           = 1'b0;
        mac_waddr        = hit_slot;
        ent_we           = 1'b0;
        ent_waddr        = tfree_slot_reg;
        wh_we            = 1'b0;

        // The station MAC never shows in a result, so only the IP is kept.
        if (cfg.valid && (cfg.index == arpc_pkg::CFG_OWN_IP))
        begin
            own_ip_next = cfg.data[31:0];
        end

        unique case (state_reg)
            arpc_pkg::BS_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next   = pop_cmd;
                    state_next = arpc_pkg::BS_MATCH;
                end
            end
            arpc_pkg::BS_MATCH:
            begin
                tmatch_next = tmatch;
                state_next  = arpc_pkg::BS_PICK;
            end
            arpc_pkg::BS_PICK:
            begin
                tfree_any_next  = ~&entry_valid_reg;
                tfree_slot_next = low_t(~entry_valid_reg);
                wfree_any_next  = ~&wait_valid_reg;
                wfree_slot_next = low_w(~wait_valid_reg);
                state_next      = arpc_pkg::BS_EXEC;
            end
            arpc_pkg::BS_EXEC:
            begin
                if (out_can)
                begin
                    state_next = arpc_pkg::BS_IDLE;
                    if (!cmd_reg.is_arp)
                    begin
                        out_valid_next = 1'b1;
                        out_next.ip    = cmd_reg.ip;
                        out_next.last  = 1'b1;
                        out_next.mac   = '0;
                        if (hit)
                        begin
                            out_next.kind   = arpc_pkg::KIND_DATA;
                            out_next.handle = cmd_reg.handle;
                            out_next.mac    = mac_rd_reg;
                        end
                        else if (wfree_any_reg)
                        begin
                            wh_we                           = 1'b1;
                            wait_valid_next[wfree_slot_reg] = 1'b1;
                            out_next.kind                   = arpc_pkg::KIND_REQUEST;
                            out_next.handle                 = '0;
                        end
                        else
                        begin
                            out_next.kind   = arpc_pkg::KIND_DROP;
                            out_next.handle = cmd_reg.handle;
                        end
                    end
                    else
                    begin
                        // Refresh an existing binding of the sender.
                        if (hit)
                        begin
                            mac_we = 1'b1;
                        end
                        if (cmd_reg.ip == own_ip_reg)
                        begin
                            if (!hit)
                            begin
                                mac_we = 1'b1;
                                ent_we = 1'b1;
                                if (!tfree_any_reg)
                                begin
                                    ent_waddr        = replace_ptr_reg;
                                    replace_ptr_next = (replace_ptr_reg == TIW'(TD - 1)) ?
                                                       '0 : replace_ptr_reg + 1'b1;
                                end
                                mac_waddr                   = ent_waddr;
                                entry_valid_next[ent_waddr] = 1'b1;
                            end
                            if (cmd_reg.is_req)
                            begin
                                out_valid_next  = 1'b1;
                                out_next.kind   = arpc_pkg::KIND_REPLY;
                                out_next.handle = '0;
                                out_next.ip     = cmd_reg.s_ip;
                                out_next.mac    = cmd_reg.s_mac;
                                out_next.last   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                cnt_next   = '0;
                                state_next = arpc_pkg::BS_REL;
                            end
                        end
                    end
                end
            end
            arpc_pkg::BS_REL:
            begin
                if ((idx_reg == WCW'(WD)) || (cnt_reg == CW'(arpc_pkg::MAX_RESULTS)))
                begin
                    state_next = arpc_pkg::BS_IDLE;
                end
                else if (wmatch[widx])
                begin
                    state_next = arpc_pkg::BS_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            arpc_pkg::BS_EMIT:
            begin
                if (out_can)
                begin
                    out_valid_next        = 1'b1;
                    out_next.kind         = arpc_pkg::KIND_DATA;
                    out_next.handle       = 8'(wh_rd_reg);
                    out_next.ip           = cmd_reg.s_ip;
                    out_next.mac          = cmd_reg.s_mac;
                    out_next.last         = !more ||
                                            (cnt_reg == CW'(arpc_pkg::MAX_RESULTS - 1));
                    wait_valid_next[widx] = 1'b0;
                    cnt_next              = cnt_reg + 1'b1;
                    idx_next              = idx_reg + 1'b1;
                    state_next            = arpc_pkg::BS_REL;
                end
            end
            default:
            begin
                state_next = arpc_pkg::BS_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= arpc_pkg::BS_IDLE;
            out_valid_reg   <= 1'b0;
            own_ip_reg      <= '0;
            entry_valid_reg <= '0;
            replace_ptr_reg <= '0;
            wait_valid_reg  <= '0;
            idx_reg         <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            own_ip_reg      <= own_ip_next;
            entry_valid_reg <= entry_valid_next;
            replace_ptr_reg <= replace_ptr_next;
            wait_valid_reg  <= wait_valid_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_reg        <= out_next;
        tmatch_reg     <= tmatch_next;
        tfree_any_reg  <= tfree_any_next;
        tfree_slot_reg <= tfree_slot_next;
        wfree_any_reg  <= wfree_any_next;
        wfree_slot_reg <= wfree_slot_next;
        if (ent_we)
        begin
            entry_ip_reg[ent_waddr] <= cmd_reg.s_ip;
        end
        if (wh_we)
        begin
            wait_ip_reg[wfree_slot_reg] <= cmd_reg.ip;
        end
    end

    // MAC memory: one write port, one registered read at the matched slot.
    always_ff @(posedge clk)
    begin
        if (mac_we)
        begin
            entry_mac_mem[mac_waddr] <= cmd_reg.s_mac;
        end
        mac_rd_reg <= entry_mac_mem[hit_slot];
    end

    // Waiting handle memory: written on park, read at the scan position.
    always_ff @(posedge clk)
    begin
        if (wh_we)
        begin
            wait_handle_mem[wfree_slot_reg] <= cmd_reg.handle[HB-1:0];
        end
        wh_rd_reg <= wait_handle_mem[widx];
    end

    `ARPC_ASSERT_IMP(a_rel_is_reply, (state_reg == arpc_pkg::BS_REL) || (state_reg == arpc_pkg::BS_EMIT), cmd_reg.is_arp && !cmd_reg.is_req, "release walk without an ARP reply")
    `ARPC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(arpc_pkg::MAX_RESULTS), "release count past limit")
    `ARPC_ASSERT_NXT(a_out_source, !out_valid_reg && (state_reg != arpc_pkg::BS_EXEC) && (state_reg != arpc_pkg::BS_EMIT), !out_valid_reg, "result raised outside an emitting state")
    `ARPC_ASSERT_IMP(a_emit_match, state_reg == arpc_pkg::BS_EMIT, wmatch[widx], "emitting a slot that does not match")

endmodule

[rtl/core/arp_resolver_cache.sv]
// ARP resolver cache, top level: front end, command queue and back end.
// Depends on arpc_pkg, arpc_if, arpc_front, arpc_cmd_queue and arpc_back.
// A send, or an ARP request that gets a reply, has its result registered after the
// table match, slot pick and MAC memory read; the back end holds one command at a
// time, and an ARP reply then scans the waiting slots and releases each matching
// handle as a result before the walk finishes.
// Reset clears all valid bits, the replace pointer and own IP; no clearing pass is run.
`timescale 1ns / 1ps

module arp_resolver_cache #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF,
    parameter int WAIT_DEPTH  = arpc_pkg::WAIT_DEPTH_DEF,
    parameter int HANDLE_BITS = arpc_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    arpc_in_if.sink     rx,
    arpc_cfg_if.sink    cfg,
    arpc_out_if.source  tx
);

    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    arpc_pkg::cmd_t push_cmd, pop_cmd;

    // Classify incoming requests.
    arpc_front #(
        .HANDLE_BITS(HANDLE_BITS)
    ) u_front (
        .rx         (rx),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decouple the two sides.
    arpc_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Execute commands against the table and waiting store.
    arpc_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .WAIT_DEPTH (WAIT_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .cfg       (cfg),
        .tx        (tx)
    );

endmodule
